// ===== src/bsha_pkg.sv =====
// Package for the board state hash accumulator.
// Opcodes, sequencer states, mixing constants and multiplier handshake structs.
// No dependencies.
package bsha_pkg;

	typedef enum logic [3:0] {
		OP_DIMS     = 4'd0,
		OP_STRBYTE  = 4'd1,
		OP_RULE_END = 4'd2,
		OP_DAMAGE   = 4'd3,
		OP_ID_END   = 4'd4,
		OP_HEALTH   = 4'd5,
		OP_LENGTH   = 4'd6,
		OP_BODY     = 4'd7,
		OP_FOOD     = 4'd8,
		OP_HAZARD   = 4'd9,
		OP_FINISH   = 4'd10
	} opcode_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MIX_ADD,
		S_MUL1_GO,
		S_MUL1_WAIT,
		S_MUL2_GO,
		S_MUL2_WAIT,
		S_MIX_END,
		S_FNV_GO,
		S_FNV_WAIT
	} seq_state_t;

	localparam logic [63:0] MIX_GOLDEN = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] MIX_MUL1   = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_MUL2   = 64'h94d049bb133111eb;
	localparam logic [63:0] FNV_BASIS  = 64'd14695981039346656037;
	localparam logic [63:0] FNV_PRIME  = 64'd1099511628211;

	localparam logic [63:0] TAG_RULE   = 64'h0000000100000000;
	localparam logic [63:0] TAG_DAMAGE = 64'h0000000200000000;
	localparam logic [63:0] TAG_ID     = 64'h0000000300000000;
	localparam logic [63:0] TAG_HEALTH = 64'h0000000400000000;
	localparam logic [63:0] TAG_LENGTH = 64'h0000000500000000;

	localparam logic [7:0] DOM_BODY   = 8'd1;
	localparam logic [7:0] DOM_FOOD   = 8'd2;
	localparam logic [7:0] DOM_HAZARD = 8'd3;

	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} mul_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [63:0] prod;
	} mul_rsp_t;

endpackage

// ===== src/bsha_mul64.sv =====
// Iterative 64x64 multiplier, low 64 bits of the product.
// One registered 32x32 multiplier, three partial products.
// Depends on bsha_pkg.
module bsha_mul64 (
	input  logic              clk,
	input  logic              arst_n,
	input  bsha_pkg::mul_req_t req,
	output bsha_pkg::mul_rsp_t rsp
);

	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [63:0] acc_q;
	logic [63:0] p_q;
	logic [1:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] op_x;
	logic [31:0] op_y;
	logic [63:0] part;

	always_comb begin
		case (cnt_q)
			2'd0: begin
				op_x = a_q[31:0];
				op_y = b_q[31:0];
			end
			2'd1: begin
				op_x = a_q[31:0];
				op_y = b_q[63:32];
			end
			default: begin
				op_x = a_q[63:32];
				op_y = b_q[31:0];
			end
		endcase
	end

	assign part = op_x * op_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
		end else if (busy_q) begin
			p_q <= part;
			case (cnt_q)
				2'd0: ;
				2'd1: acc_q <= p_q;
				default: acc_q <= acc_q + {p_q[31:0], 32'h0};
			endcase
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

endmodule

// ===== src/board_state_hash_accumulator.sv =====
// Board state hash accumulator: splitmix64-mixed keys XORed into a 64-bit hash,
// FNV-1a over string bytes. Depends on bsha_pkg and bsha_mul64.
//
//   channel  handshake              payload
//   in       in_valid / in_ready    opcode, coord_x, coord_y, snake_number,
//                                   word_value, text_byte
//   out      out_valid / out_ready  board_hash
//
// Every mix and FNV step runs on the shared multiplier (launch, then wait for done):
// one mix is add, two multiplies, fold; dims, rule_end, damage, id_end, health and
// length run one mix, body, food and hazard two, a nonzero string byte one multiply;
// finish, zero bytes and unused opcodes use no multiplier and stay in idle.
// Reset clears the hash, damage word and output valid, and loads the FNV basis.
// A pending result does not block non-finish transactions; finish waits on it.
module board_state_hash_accumulator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  opcode,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic [7:0]  snake_number,
	input  logic [31:0] word_value,
	input  logic [7:0]  text_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] board_hash
);

	bsha_pkg::seq_state_t state_q;
	bsha_pkg::seq_state_t state_d;
	bsha_pkg::mul_req_t   mul_req;
	bsha_pkg::mul_rsp_t   mul_rsp;

	logic [63:0] hash_accum_q;
	logic [63:0] text_hash_q;
	logic [31:0] damage_word_q;
	logic [63:0] v_q;
	logic [63:0] base_q;
	logic        two_pass_q;
	logic        out_valid_q;
	logic [63:0] board_hash_q;

	logic        in_acc;
	logic        is_finish;
	logic        out_free;
	logic [63:0] xy_key;
	logic [63:0] sn_key;
	logic [63:0] mix_out;

	assign out_free  = !out_valid_q || out_ready;
	assign is_finish = (opcode == bsha_pkg::OP_FINISH);
	assign in_ready  = (state_q == bsha_pkg::S_IDLE) && (out_free || !is_finish);
	assign in_acc    = in_valid && in_ready;
	assign xy_key    = {coord_x, coord_y};
	assign sn_key    = {24'h0, snake_number, 32'h0};
	assign mix_out   = v_q ^ (v_q >> 31);

	bsha_mul64 u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			bsha_pkg::S_IDLE: begin
				if (in_acc) begin
					case (opcode)
						bsha_pkg::OP_DIMS, bsha_pkg::OP_RULE_END, bsha_pkg::OP_DAMAGE,
						bsha_pkg::OP_ID_END, bsha_pkg::OP_HEALTH, bsha_pkg::OP_LENGTH,
						bsha_pkg::OP_BODY, bsha_pkg::OP_FOOD, bsha_pkg::OP_HAZARD:
							state_d = bsha_pkg::S_MIX_ADD;
						bsha_pkg::OP_STRBYTE:
							if (text_byte != 8'h0) state_d = bsha_pkg::S_FNV_GO;
						default: state_d = bsha_pkg::S_IDLE;
					endcase
				end
			end
			bsha_pkg::S_MIX_ADD:   state_d = bsha_pkg::S_MUL1_GO;
			bsha_pkg::S_MUL1_GO:   state_d = bsha_pkg::S_MUL1_WAIT;
			bsha_pkg::S_MUL1_WAIT: if (mul_rsp.done) state_d = bsha_pkg::S_MUL2_GO;
			bsha_pkg::S_MUL2_GO:   state_d = bsha_pkg::S_MUL2_WAIT;
			bsha_pkg::S_MUL2_WAIT: if (mul_rsp.done) state_d = bsha_pkg::S_MIX_END;
			bsha_pkg::S_MIX_END:
				state_d = two_pass_q ? bsha_pkg::S_MIX_ADD : bsha_pkg::S_IDLE;
			bsha_pkg::S_FNV_GO:    state_d = bsha_pkg::S_FNV_WAIT;
			bsha_pkg::S_FNV_WAIT:  if (mul_rsp.done) state_d = bsha_pkg::S_IDLE;
			default:               state_d = bsha_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		mul_req.start = 1'b0;
		mul_req.a     = v_q ^ (v_q >> 30);
		mul_req.b     = bsha_pkg::MIX_MUL1;
		case (state_q)
			bsha_pkg::S_MUL1_GO: mul_req.start = 1'b1;
			bsha_pkg::S_MUL2_GO: begin
				mul_req.start = 1'b1;
				mul_req.a     = v_q ^ (v_q >> 27);
				mul_req.b     = bsha_pkg::MIX_MUL2;
			end
			bsha_pkg::S_FNV_GO: begin
				mul_req.start = 1'b1;
				mul_req.a     = v_q;
				mul_req.b     = bsha_pkg::FNV_PRIME;
			end
			default: mul_req.start = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= bsha_pkg::S_IDLE;
			hash_accum_q  <= 64'h0;
			text_hash_q   <= bsha_pkg::FNV_BASIS;
			damage_word_q <= 32'h0;
			two_pass_q    <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				bsha_pkg::S_IDLE: begin
					if (in_acc) begin
						two_pass_q <= 1'b0;
						case (opcode)
							bsha_pkg::OP_RULE_END, bsha_pkg::OP_ID_END:
								text_hash_q <= bsha_pkg::FNV_BASIS;
							bsha_pkg::OP_DAMAGE: damage_word_q <= word_value;
							bsha_pkg::OP_BODY, bsha_pkg::OP_FOOD, bsha_pkg::OP_HAZARD:
								two_pass_q <= 1'b1;
							bsha_pkg::OP_FINISH: begin
								out_valid_q   <= 1'b1;
								hash_accum_q  <= 64'h0;
								text_hash_q   <= bsha_pkg::FNV_BASIS;
								damage_word_q <= 32'h0;
							end
							default: ;
						endcase
					end
				end
				bsha_pkg::S_MIX_END: begin
					if (two_pass_q) two_pass_q <= 1'b0;
					else hash_accum_q <= hash_accum_q ^ mix_out;
				end
				bsha_pkg::S_FNV_WAIT: if (mul_rsp.done) text_hash_q <= mul_rsp.prod;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			bsha_pkg::S_IDLE: begin
				if (in_acc) begin
					case (opcode)
						bsha_pkg::OP_DIMS:     v_q <= xy_key;
						bsha_pkg::OP_STRBYTE:  v_q <= text_hash_q ^ {56'h0, text_byte};
						bsha_pkg::OP_RULE_END: v_q <= text_hash_q ^ bsha_pkg::TAG_RULE;
						bsha_pkg::OP_DAMAGE:   v_q <= {32'h0, word_value} ^ bsha_pkg::TAG_DAMAGE;
						bsha_pkg::OP_ID_END:
							v_q <= text_hash_q ^ sn_key ^ bsha_pkg::TAG_ID;
						bsha_pkg::OP_HEALTH:
							v_q <= {32'h0, word_value} ^ sn_key ^ bsha_pkg::TAG_HEALTH;
						bsha_pkg::OP_LENGTH:
							v_q <= {32'h0, word_value} ^ sn_key ^ bsha_pkg::TAG_LENGTH;
						bsha_pkg::OP_BODY: begin
							v_q    <= {32'h0, word_value};
							base_q <= xy_key ^ {40'h0, snake_number, bsha_pkg::DOM_BODY, 8'h0};
						end
						bsha_pkg::OP_FOOD: begin
							v_q    <= 64'h0;
							base_q <= xy_key ^ {48'h0, bsha_pkg::DOM_FOOD, 8'h0};
						end
						bsha_pkg::OP_HAZARD: begin
							v_q    <= {32'h0, damage_word_q};
							base_q <= xy_key ^ {48'h0, bsha_pkg::DOM_HAZARD, 8'h0};
						end
						default: ;
					endcase
					if (is_finish) board_hash_q <= hash_accum_q;
				end
			end
			bsha_pkg::S_MIX_ADD: v_q <= v_q + bsha_pkg::MIX_GOLDEN;
			bsha_pkg::S_MUL1_WAIT, bsha_pkg::S_MUL2_WAIT:
				if (mul_rsp.done) v_q <= mul_rsp.prod;
			bsha_pkg::S_MIX_END: if (two_pass_q) v_q <= base_q ^ mix_out;
			default: ;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign board_hash = board_hash_q;

`ifndef NO_ASSERTIONS
	a_finish_emits: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && is_finish |=> out_valid && hash_accum_q == 64'h0
			&& text_hash_q == bsha_pkg::FNV_BASIS)
		else $error("finish did not emit a result and clear state");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> state_q == bsha_pkg::S_MUL1_WAIT
			|| state_q == bsha_pkg::S_MUL2_WAIT || state_q == bsha_pkg::S_FNV_WAIT)
		else $error("multiplier finished outside a wait state");

	a_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		mul_req.start |-> !mul_rsp.busy)
		else $error("multiplier restarted while busy");
`endif

endmodule
